/* sv/tma_pkg.sv */
package tma_pkg;

   localparam int WINDOW   = 26;
   localparam int CHANNELS = 8;

   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 4;
   localparam int SUM_W    = 22;
   localparam int NUM_W    = SUM_W + 1;
   localparam int PTR_W    = $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH    = CHANNELS * WINDOW;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int DIV_W     = NUM_W + (NUM_W % 2);
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
   localparam int PC_W     = 4;

   localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

   localparam logic FUNC_FILTER = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_BAD_CH = 1'b1;

   typedef struct packed {
      logic                       func;
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       status;
      logic                       window_full;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_RD_OLD,
      OP_UPDATE,
      OP_SCAN_FIRST,
      OP_SCAN,
      OP_TRIM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_DONE,
      OP_SET_ERR,
      OP_CLEAR,
      OP_SEND
   } op_type;

   typedef enum logic [3:0] {
      C_NONE,
      C_ALWAYS,
      C_NO_REQ,
      C_BAD_CH,
      C_CLEAR,
      C_NOT_FULL,
      C_SCAN_MORE,
      C_DIV_MORE,
      C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic bad_ch;
      logic clear;
      logic not_full;
      logic scan_more;
      logic div_more;
      logic rsp_busy;
   } flags_type;

   typedef struct packed {
      logic more;
      logic done;
   } div_stat_type;

   localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
   localparam logic [PC_W-1:0] PC_CHECK    = 4'd1;
   localparam logic [PC_W-1:0] PC_KIND     = 4'd2;
   localparam logic [PC_W-1:0] PC_RD_OLD   = 4'd3;
   localparam logic [PC_W-1:0] PC_UPDATE   = 4'd4;
   localparam logic [PC_W-1:0] PC_SCAN0    = 4'd5;
   localparam logic [PC_W-1:0] PC_SCAN     = 4'd6;
   localparam logic [PC_W-1:0] PC_TRIM     = 4'd7;
   localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd8;
   localparam logic [PC_W-1:0] PC_DIV      = 4'd9;
   localparam logic [PC_W-1:0] PC_DIV_DONE = 4'd10;
   localparam logic [PC_W-1:0] PC_ERR      = 4'd11;
   localparam logic [PC_W-1:0] PC_CLEAR    = 4'd12;
   localparam logic [PC_W-1:0] PC_SEND     = 4'd13;
   localparam logic [PC_W-1:0] PC_RETURN   = 4'd14;

endpackage

/* sv/tma_store.sv */
module tma_store (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [tma_pkg::ADDR_W-1:0]         wr_addr,
   input  logic signed [tma_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic [tma_pkg::ADDR_W-1:0]         rd_addr,
   output logic signed [tma_pkg::SAMPLE_W-1:0] rd_data
);

   logic signed [tma_pkg::SAMPLE_W-1:0] store_ff [tma_pkg::DEPTH];
   logic signed [tma_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tma_div.sv */
module tma_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic                                step,
   input  logic signed [tma_pkg::NUM_W-1:0]    num,
   input  logic [tma_pkg::CNT_W-1:0]           den,
   output logic signed [tma_pkg::SAMPLE_W-1:0] quot,
   output tma_pkg::div_stat_type               stat
);

   logic [tma_pkg::CNT_W-1:0]  rem_ff, rem_in, rem_v;
   logic [tma_pkg::DIV_W-1:0]  dq_ff, dq_in, dq_v;
   logic [tma_pkg::CNT_W-1:0]  den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic [tma_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic [tma_pkg::CNT_W:0]    trial;
   logic [tma_pkg::NUM_W-1:0]  mag;
   logic [tma_pkg::SAMPLE_W-1:0] q_low;

   // Two restoring steps per cycle while step is asserted; the quotient shifts into the dividend register.
   always_comb begin
      rem_v = rem_ff;
      dq_v  = dq_ff;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
         trial = {rem_v, dq_v[tma_pkg::DIV_W-1]};
         dq_v  = {dq_v[tma_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_v   = tma_pkg::CNT_W'(trial - {1'b0, den_ff});
            dq_v[0] = 1'b1;
         end else begin
            rem_v = trial[tma_pkg::CNT_W-1:0];
         end
      end
   end

   assign mag = num[tma_pkg::NUM_W-1] ? tma_pkg::NUM_W'(-num) : tma_pkg::NUM_W'(num);

   always_comb begin
      rem_in = rem_ff;
      dq_in  = dq_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = '0;
         dq_in  = tma_pkg::DIV_W'(mag);
         den_in = den;
         neg_in = num[tma_pkg::NUM_W-1];
         cnt_in = tma_pkg::DCNT_W'(tma_pkg::DIV_STEPS);
      end else if (step) begin
         rem_in = rem_v;
         dq_in  = dq_v;
         cnt_in = cnt_ff - tma_pkg::DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign q_low     = dq_ff[tma_pkg::SAMPLE_W-1:0];
   assign quot      = neg_ff ? -q_low : q_low;
   assign stat.more = cnt_ff > tma_pkg::DCNT_W'(1);
   assign stat.done = cnt_ff == '0;

endmodule

/* sv/tma_seq.sv */
module tma_seq (
   input  logic                clock,
   input  logic                reset,
   input  tma_pkg::flags_type  flags,
   output tma_pkg::ucode_type  ctrl
);

   logic [tma_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                     take;

   always_comb begin
      case (pc_ff)
         tma_pkg::PC_FETCH:
            ctrl = '{op: tma_pkg::OP_LOAD, cond: tma_pkg::C_NO_REQ, target: tma_pkg::PC_FETCH};
         tma_pkg::PC_CHECK:
            ctrl = '{op: tma_pkg::OP_NOP, cond: tma_pkg::C_BAD_CH, target: tma_pkg::PC_ERR};
         tma_pkg::PC_KIND:
            ctrl = '{op: tma_pkg::OP_NOP, cond: tma_pkg::C_CLEAR, target: tma_pkg::PC_CLEAR};
         tma_pkg::PC_RD_OLD:
            ctrl = '{op: tma_pkg::OP_RD_OLD, cond: tma_pkg::C_NONE, target: tma_pkg::PC_FETCH};
         tma_pkg::PC_UPDATE:
            ctrl = '{op: tma_pkg::OP_UPDATE, cond: tma_pkg::C_NOT_FULL,
                     target: tma_pkg::PC_DIV_INIT};
         tma_pkg::PC_SCAN0:
            ctrl = '{op: tma_pkg::OP_SCAN_FIRST, cond: tma_pkg::C_NONE,
                     target: tma_pkg::PC_FETCH};
         tma_pkg::PC_SCAN:
            ctrl = '{op: tma_pkg::OP_SCAN, cond: tma_pkg::C_SCAN_MORE, target: tma_pkg::PC_SCAN};
         tma_pkg::PC_TRIM:
            ctrl = '{op: tma_pkg::OP_TRIM, cond: tma_pkg::C_NONE, target: tma_pkg::PC_FETCH};
         tma_pkg::PC_DIV_INIT:
            ctrl = '{op: tma_pkg::OP_DIV_INIT, cond: tma_pkg::C_NONE, target: tma_pkg::PC_FETCH};
         tma_pkg::PC_DIV:
            ctrl = '{op: tma_pkg::OP_DIV_STEP, cond: tma_pkg::C_DIV_MORE, target: tma_pkg::PC_DIV};
         tma_pkg::PC_DIV_DONE:
            ctrl = '{op: tma_pkg::OP_DIV_DONE, cond: tma_pkg::C_ALWAYS, target: tma_pkg::PC_SEND};
         tma_pkg::PC_ERR:
            ctrl = '{op: tma_pkg::OP_SET_ERR, cond: tma_pkg::C_ALWAYS, target: tma_pkg::PC_SEND};
         tma_pkg::PC_CLEAR:
            ctrl = '{op: tma_pkg::OP_CLEAR, cond: tma_pkg::C_NONE, target: tma_pkg::PC_FETCH};
         tma_pkg::PC_SEND:
            ctrl = '{op: tma_pkg::OP_SEND, cond: tma_pkg::C_RSP_BUSY, target: tma_pkg::PC_SEND};
         tma_pkg::PC_RETURN:
            ctrl = '{op: tma_pkg::OP_NOP, cond: tma_pkg::C_ALWAYS, target: tma_pkg::PC_FETCH};
         default:
            ctrl = '{op: tma_pkg::OP_NOP, cond: tma_pkg::C_ALWAYS, target: tma_pkg::PC_FETCH};
      endcase
   end

   always_comb begin
      case (ctrl.cond)
         tma_pkg::C_NONE:      take = 1'b0;
         tma_pkg::C_ALWAYS:    take = 1'b1;
         tma_pkg::C_NO_REQ:    take = flags.no_req;
         tma_pkg::C_BAD_CH:    take = flags.bad_ch;
         tma_pkg::C_CLEAR:     take = flags.clear;
         tma_pkg::C_NOT_FULL:  take = flags.not_full;
         tma_pkg::C_SCAN_MORE: take = flags.scan_more;
         tma_pkg::C_DIV_MORE:  take = flags.div_more;
         tma_pkg::C_RSP_BUSY:  take = flags.rsp_busy;
         default:              take = 1'b0;
      endcase
   end

   assign pc_in = take ? ctrl.target : pc_ff + tma_pkg::PC_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tma_pkg::PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* sv/trimmed_moving_average_multichannel.sv */
// Trimmed moving-average filter with an independent window per channel.
// Request channel (req_valid/req_ready/req_data) carries one item: a sample
// to filter or a clear command for one channel. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns exactly one result per item, in order.
// A microcoded sequencer steps a shared datapath: one read of the sample
// memory per cycle for the window scan and a radix-4 restoring divider.
// A full-window item is scanned for min/max one sample at a time, trimmed and
// divided; while the window fills the sum goes straight to the divider; a
// clear and a bad channel skip both. Items are handled one at a time: the
// next item is accepted only after the result is loaded, via a return step.
// Reset returns every channel to an empty window at once; the sample memory
// is not swept because entries beyond the fill count are never used.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result in its result register and waits before loading it.
module trimmed_moving_average_multichannel (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tma_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tma_pkg::rsp_type  rsp_data
);

   tma_pkg::ucode_type    ctrl;
   tma_pkg::flags_type    flags;
   tma_pkg::div_stat_type div_st;

   tma_pkg::req_type req_ff, req_in;
   tma_pkg::rsp_type res_ff, res_in;
   tma_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_free;

   logic signed [tma_pkg::SUM_W-1:0] sum_ff  [tma_pkg::CHANNELS];
   logic signed [tma_pkg::SUM_W-1:0] sum_in  [tma_pkg::CHANNELS];
   logic [tma_pkg::PTR_W-1:0]        ptr_ff  [tma_pkg::CHANNELS];
   logic [tma_pkg::PTR_W-1:0]        ptr_in  [tma_pkg::CHANNELS];
   logic [tma_pkg::CNT_W-1:0]        fill_ff [tma_pkg::CHANNELS];
   logic [tma_pkg::CNT_W-1:0]        fill_in [tma_pkg::CHANNELS];
   logic                             full_ff [tma_pkg::CHANNELS];
   logic                             full_in [tma_pkg::CHANNELS];

   logic [tma_pkg::CH_W-1:0]         ch_idx;
   logic signed [tma_pkg::SUM_W-1:0] sum_rd, sum_new;
   logic [tma_pkg::PTR_W-1:0]        ptr_rd;
   logic [tma_pkg::CNT_W-1:0]        fill_rd, fill_inc;
   logic                             full_rd;

   logic [tma_pkg::ADDR_W-1:0]          base;
   logic                                st_wr_en, st_rd_en;
   logic [tma_pkg::ADDR_W-1:0]          st_wr_addr, st_rd_addr;
   logic signed [tma_pkg::SAMPLE_W-1:0] st_rd_data, old_val;

   logic [tma_pkg::CNT_W-1:0]           idx_ff, idx_in;
   logic signed [tma_pkg::SAMPLE_W-1:0] mx_ff, mx_in, mn_ff, mn_in;
   logic signed [tma_pkg::NUM_W-1:0]    num_ff, num_in, trim_num;
   logic [tma_pkg::CNT_W-1:0]           den_ff, den_in;
   logic                                trim_ff, trim_in;
   logic                                div_load, div_step;
   logic signed [tma_pkg::SAMPLE_W-1:0] div_quot;

   tma_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   tma_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (req_ff.sample),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   tma_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (div_load),
      .step  (div_step),
      .num   (num_ff),
      .den   (den_ff),
      .quot  (div_quot),
      .stat  (div_st)
   );

   assign ch_idx   = req_ff.channel[tma_pkg::CH_W-1:0];
   assign sum_rd   = sum_ff[ch_idx];
   assign ptr_rd   = ptr_ff[ch_idx];
   assign fill_rd  = fill_ff[ch_idx];
   assign full_rd  = full_ff[ch_idx];
   assign fill_inc = fill_rd + tma_pkg::CNT_W'(1);
   assign base     = tma_pkg::ADDR_W'(ch_idx) * tma_pkg::ADDR_W'(tma_pkg::WINDOW);

   // Before the window is full, the slot at the pointer has not been written since clear.
   assign old_val  = full_rd ? st_rd_data : '0;
   assign sum_new  = sum_rd + tma_pkg::SUM_W'(req_ff.sample) - tma_pkg::SUM_W'(old_val);
   assign trim_num = tma_pkg::NUM_W'(sum_rd) - tma_pkg::NUM_W'(mx_ff) - tma_pkg::NUM_W'(mn_ff);

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctrl.op == tma_pkg::OP_LOAD;

   always_comb begin
      flags.no_req    = !req_valid;
      flags.bad_ch    = {1'b0, req_ff.channel} >= tma_pkg::CH_LIMIT;
      flags.clear     = req_ff.func == tma_pkg::FUNC_CLEAR;
      flags.not_full  = !full_rd;
      flags.scan_more = idx_ff != tma_pkg::CNT_W'(tma_pkg::WINDOW);
      flags.div_more  = div_st.more;
      flags.rsp_busy  = !rsp_free;
   end

   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      sum_in       = sum_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      full_in      = full_ff;
      idx_in       = idx_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      trim_in      = trim_ff;
      st_wr_en     = 1'b0;
      st_rd_en     = 1'b0;
      st_wr_addr   = base + tma_pkg::ADDR_W'(ptr_rd);
      st_rd_addr   = base + tma_pkg::ADDR_W'(ptr_rd);
      div_load     = 1'b0;
      div_step     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (ctrl.op)
         tma_pkg::OP_LOAD: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         tma_pkg::OP_RD_OLD: begin
            st_rd_en = 1'b1;
         end
         tma_pkg::OP_UPDATE: begin
            st_wr_en       = 1'b1;
            sum_in[ch_idx] = sum_new;
            ptr_in[ch_idx] = (ptr_rd == tma_pkg::PTR_W'(tma_pkg::WINDOW - 1)) ?
                             '0 : ptr_rd + tma_pkg::PTR_W'(1);
            if (!full_rd) begin
               fill_in[ch_idx] = fill_inc;
               if (fill_inc == tma_pkg::CNT_W'(tma_pkg::WINDOW)) begin
                  full_in[ch_idx] = 1'b1;
               end
            end
            num_in  = tma_pkg::NUM_W'(sum_new);
            den_in  = fill_inc;
            trim_in = full_rd;
         end
         tma_pkg::OP_SCAN_FIRST: begin
            st_rd_en   = 1'b1;
            st_rd_addr = base;
            idx_in     = tma_pkg::CNT_W'(1);
         end
         tma_pkg::OP_SCAN: begin
            st_rd_en   = idx_ff != tma_pkg::CNT_W'(tma_pkg::WINDOW);
            st_rd_addr = base + tma_pkg::ADDR_W'(idx_ff);
            idx_in     = idx_ff + tma_pkg::CNT_W'(1);
            if (idx_ff == tma_pkg::CNT_W'(1)) begin
               mx_in = st_rd_data;
               mn_in = st_rd_data;
            end else begin
               if (st_rd_data > mx_ff) begin
                  mx_in = st_rd_data;
               end
               if (st_rd_data < mn_ff) begin
                  mn_in = st_rd_data;
               end
            end
         end
         tma_pkg::OP_TRIM: begin
            num_in = trim_num;
            den_in = tma_pkg::CNT_W'(tma_pkg::WINDOW - 2);
         end
         tma_pkg::OP_DIV_INIT: begin
            div_load = 1'b1;
         end
         tma_pkg::OP_DIV_STEP: begin
            div_step = 1'b1;
         end
         tma_pkg::OP_DIV_DONE: begin
            res_in = '{filtered: div_quot, status: tma_pkg::STATUS_OK, window_full: trim_ff};
         end
         tma_pkg::OP_SET_ERR: begin
            res_in = '{filtered: '0, status: tma_pkg::STATUS_BAD_CH, window_full: 1'b0};
         end
         tma_pkg::OP_CLEAR: begin
            sum_in[ch_idx]  = '0;
            ptr_in[ch_idx]  = '0;
            fill_in[ch_idx] = '0;
            full_in[ch_idx] = 1'b0;
            res_in = '{filtered: '0, status: tma_pkg::STATUS_OK, window_full: 1'b0};
         end
         tma_pkg::OP_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < tma_pkg::CHANNELS; c++) begin
            sum_ff[c]  <= '0;
            ptr_ff[c]  <= '0;
            fill_ff[c] <= '0;
            full_ff[c] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         full_ff      <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= idx_in;
      mx_ff       <= mx_in;
      mn_ff       <= mn_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      trim_ff     <= trim_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == tma_pkg::OP_UPDATE) && !full_rd |-> tma_pkg::CNT_W'(ptr_rd) == fill_rd)
      else $error("Write pointer and fill count disagree on a filling window.");

   a_leave_fetch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Sequencer stayed in fetch after taking an item.");

   a_div_finished: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == tma_pkg::OP_DIV_DONE |-> div_st.done)
      else $error("Quotient taken before the divider finished.");

   a_rsp_from_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == tma_pkg::OP_SEND))
      else $error("Result register loaded outside the send step.");

endmodule

/* tb/sv/tb_trimmed_moving_average_multichannel.sv */
module tb_trimmed_moving_average_multichannel;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   tma_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   tma_pkg::rsp_type rsp_data;

   trimmed_moving_average_multichannel DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   logic signed [tma_pkg::SAMPLE_W-1:0] win_store [tma_pkg::CHANNELS][tma_pkg::WINDOW];
   int      win_sum   [tma_pkg::CHANNELS];
   int      win_ptr   [tma_pkg::CHANNELS];
   int      win_count [tma_pkg::CHANNELS];
   bit      win_full  [tma_pkg::CHANNELS];
   tma_pkg::rsp_type results_due [$];

   int error_count;
   int items_sent;
   int clears_sent;
   int bad_sent;
   int results_seen;
   int trimmed_seen;
   bit idle_enable;
   int rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void empty_window(input int ch);
      for (int i = 0; i < tma_pkg::WINDOW; i++) begin
         win_store[ch][i] = '0;
      end
      win_sum[ch]   = 0;
      win_ptr[ch]   = 0;
      win_count[ch] = 0;
      win_full[ch]  = 1'b0;
   endfunction

   function automatic tma_pkg::rsp_type trimmed_mean_of(input tma_pkg::req_type item);
      tma_pkg::rsp_type r;
      int      ch;
      int      p;
      int      hi;
      int      lo;
      r  = '0;
      ch = item.channel;
      if (ch >= tma_pkg::CHANNELS) begin
         r.status = tma_pkg::STATUS_BAD_CH;
         return r;
      end
      r.status = tma_pkg::STATUS_OK;
      if (item.func == tma_pkg::FUNC_CLEAR) begin
         empty_window(ch);
         return r;
      end
      p = win_ptr[ch];
      win_sum[ch] += int'(item.sample) - int'(win_store[ch][p]);
      win_store[ch][p] = item.sample;
      win_ptr[ch] = (p + 1 == tma_pkg::WINDOW) ? 0 : p + 1;
      if (win_full[ch]) begin
         hi = win_store[ch][0];
         lo = win_store[ch][0];
         for (int i = 1; i < tma_pkg::WINDOW; i++) begin
            if (int'(win_store[ch][i]) > hi) hi = win_store[ch][i];
            if (int'(win_store[ch][i]) < lo) lo = win_store[ch][i];
         end
         r.filtered    = tma_pkg::SAMPLE_W'((win_sum[ch] - hi - lo) / (tma_pkg::WINDOW - 2));
         r.window_full = 1'b1;
      end else begin
         if (win_count[ch] < tma_pkg::WINDOW) win_count[ch]++;
         r.filtered = tma_pkg::SAMPLE_W'(win_sum[ch] / win_count[ch]);
         if (win_count[ch] >= tma_pkg::WINDOW) win_full[ch] = 1'b1;
      end
      return r;
   endfunction

   task automatic send_item(input tma_pkg::req_type item);
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(99) < 7) begin
            req_valid <= 1'b0;
         end else begin
            break;
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      results_due.push_back(trimmed_mean_of(item));
      items_sent++;
      if (item.channel >= tma_pkg::CHANNELS) bad_sent++;
      else if (item.func == tma_pkg::FUNC_CLEAR) clears_sent++;
   endtask

   task automatic send_fields(input logic func, input int ch, input int sample);
      tma_pkg::req_type item;
      item.func    = func;
      item.channel = tma_pkg::CHAN_W'(ch);
      item.sample  = tma_pkg::SAMPLE_W'(sample);
      send_item(item);
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic tma_pkg::req_type random_item();
      tma_pkg::req_type item;
      int      pick;
      int      ch;
      pick = $urandom_range(99);
      ch   = $urandom_range(tma_pkg::CHANNELS - 1);
      item.func    = tma_pkg::FUNC_FILTER;
      item.channel = tma_pkg::CHAN_W'(ch);
      item.sample  = tma_pkg::SAMPLE_W'($urandom());
      if (pick < 3) begin
         item.func = tma_pkg::FUNC_CLEAR;
      end else if (pick < 8 && tma_pkg::CHANNELS < 16) begin
         item.func    = logic'($urandom_range(1));
         item.channel = tma_pkg::CHAN_W'($urandom_range(15, tma_pkg::CHANNELS));
      end else begin
         case ($urandom_range(3))
            0: item.sample = tma_pkg::SAMPLE_W'($urandom());
            1: begin
               case ($urandom_range(3))
                  0: item.sample = 16'sh7fff;
                  1: item.sample = 16'sh8000;
                  2: item.sample = 16'sh0000;
                  default: item.sample = 16'shffff;
               endcase
            end
            default: item.sample = tma_pkg::SAMPLE_W'(ch * 1000 - 4000
                                                      + $urandom_range(64) - 32);
         endcase
      end
      return item;
   endfunction

   task automatic test_directed();
      send_fields(tma_pkg::FUNC_FILTER, 0, 100);
      send_fields(tma_pkg::FUNC_FILTER, 0, -50);
      send_fields(tma_pkg::FUNC_FILTER, 1, 32767);
      send_fields(tma_pkg::FUNC_FILTER, 1, 32767);
      send_fields(tma_pkg::FUNC_FILTER, 2, -32768);
      send_fields(tma_pkg::FUNC_FILTER, 2, -32768);
      send_fields(tma_pkg::FUNC_FILTER, 3, -1);
      send_fields(tma_pkg::FUNC_FILTER, 3, 0);
      send_fields(tma_pkg::FUNC_FILTER, 3, -2);
      send_fields(tma_pkg::FUNC_FILTER, 4, 1);
      send_fields(tma_pkg::FUNC_FILTER, 4, 0);
      send_fields(tma_pkg::FUNC_FILTER, 8, 1234);
      send_fields(tma_pkg::FUNC_CLEAR, 15, -1);
      send_fields(tma_pkg::FUNC_FILTER, 12, -1);
      send_fields(tma_pkg::FUNC_CLEAR, 1, 32767);
      send_fields(tma_pkg::FUNC_FILTER, 1, 5);
      send_fields(tma_pkg::FUNC_CLEAR, 7, 0);
      send_fields(tma_pkg::FUNC_FILTER, 7, -32768);
      send_fields(tma_pkg::FUNC_FILTER, 5, 16'h5555);
      send_fields(tma_pkg::FUNC_FILTER, 6, 16'haaaa);
      end_requests();
   endtask

   task automatic test_window_fill();
      send_fields(tma_pkg::FUNC_CLEAR, 0, 0);
      for (int i = 0; i < 32; i++) begin
         case (i % 4)
            0: send_fields(tma_pkg::FUNC_FILTER, 0, 32767);
            1: send_fields(tma_pkg::FUNC_FILTER, 0, -32768);
            default: send_fields(tma_pkg::FUNC_FILTER, 0, $urandom_range(2000) - 1000);
         endcase
      end
      send_fields(tma_pkg::FUNC_CLEAR, 1, 0);
      for (int i = 0; i < 28; i++) begin
         send_fields(tma_pkg::FUNC_FILTER, 1, 32767);
      end
      send_fields(tma_pkg::FUNC_CLEAR, 2, 0);
      for (int i = 0; i < 28; i++) begin
         send_fields(tma_pkg::FUNC_FILTER, 2, -32768);
      end
      end_requests();
   endtask

   task automatic test_backpressure();
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 10; i++) begin
         send_fields(tma_pkg::FUNC_FILTER, 3, $urandom_range(65535));
      end
      end_requests();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(random_item());
      end
      end_requests();
   endtask

   initial begin : rsp_driver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_enable && $urandom_range(99) < 7);
         end
      end
   end

   initial begin : rsp_checker
      tma_pkg::rsp_type due;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               $error("result with no item outstanding: %p", rsp_data);
               error_count++;
            end else begin
               due = results_due.pop_front();
               if (rsp_data.filtered !== due.filtered) begin
                  $error("filtered: expected %0d, actual %0d", due.filtered, rsp_data.filtered);
                  error_count++;
               end
               if (rsp_data.status !== due.status) begin
                  $error("status: expected %0b, actual %0b", due.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.window_full !== due.window_full) begin
                  $error("window_full: expected %0b, actual %0b",
                         due.window_full, rsp_data.window_full);
                  error_count++;
               end
               if (due.window_full) trimmed_seen++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Timed out after %0d cycles with no item moving.", STALL_LIMIT);
      $display("** trimmed_moving_average_multichannel: FAILED **");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      idle_enable     = 1'b1;
      rsp_hold_cycles = 0;
      error_count     = 0;
      items_sent      = 0;
      clears_sent     = 0;
      bad_sent        = 0;
      results_seen    = 0;
      trimmed_seen    = 0;
      for (int ch = 0; ch < tma_pkg::CHANNELS; ch++) begin
         empty_window(ch);
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_window_fill();
      test_backpressure();
      test_random(110);
      idle_enable = 1'b0;
      test_random(100);
      idle_enable = 1'b1;
      test_random(120);

      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d clears, %0d to invalid channels); checked %0d results.",
               items_sent, clears_sent, bad_sent, results_seen);
      $display("%0d results used the trimmed mean over a full window.", trimmed_seen);
      if (error_count == 0 && results_due.size() == 0) begin
         $display("** trimmed_moving_average_multichannel: PASSED **");
      end else begin
         $display("** trimmed_moving_average_multichannel: FAILED **");
      end
      $finish;
   end

endmodule
